[src/spll_pkg.sv]
// Package: types, codes and helpers shared by the slot pool linked list block.
`default_nettype none
package spll_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_W     = 7;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int SCAN_W   = 8;

  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]      func;
    logic [ID_W-1:0] slot_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] result_id;
    logic [ID_W-1:0] prev_link;
    logic [ID_W-1:0] next_link;
    logic            entry_used;
    logic [ID_W-1:0] live_count;
    logic [ID_W-1:0] head_slot;
    logic [ID_W-1:0] tail_slot;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALW1,
    S_ALW2,
    S_SCAN,
    S_RD,
    S_LNK,
    S_FIN
  } state_t;

  function automatic logic id_in_range(input logic [ID_W-1:0] id);
    return (id != '0) && (id <= ID_W'(CAPACITY));
  endfunction

  function automatic logic [IDX_W-1:0] idx_of(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] d;
    d = id - ID_W'(1);
    return d[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

[src/slot_pool_linked_list_core.sv]
// Slot pool allocator: used bits, linked list memories and sequencer.
// Allocate: ALW1 and ALW2, then SCAN until a free slot is found (8 used bits per cycle), then FIN.
// Free and query of an in-range id: result through the RD, LNK and FIN states, set by the link read.
// Allocate into a full pool, bad id or unknown func: straight to FIN, which loads the result.
// Next item taken the cycle after a result loads; a stalled result holds the next in FIN.
// Synchronous active-low reset: pool empty, head, tail and lowest free 1, link valids clear.
`default_nettype none
module slot_pool_linked_list_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire spll_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output spll_pkg::out_item_t     out_data
);

  localparam int ID_W  = spll_pkg::ID_W;
  localparam int IDX_W = spll_pkg::IDX_W;
  localparam int CAP   = spll_pkg::CAPACITY;
  localparam int SW    = spll_pkg::SCAN_W;
  localparam int SK_W  = $clog2(spll_pkg::SCAN_W);

  spll_pkg::state_t state_r, state_nxt;

  logic [1:0]      op_r, op_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [1:0]      stat_r, stat_nxt;
  logic [ID_W-1:0] rid_r, rid_nxt;
  logic [ID_W-1:0] head_r, head_nxt;
  logic [ID_W-1:0] tail_r, tail_nxt;
  logic [ID_W-1:0] cnt_r, cnt_nxt;
  logic [ID_W-1:0] lf_r, lf_nxt;
  logic [CAP-1:0]  used_r, used_nxt;
  logic            out_valid_r, out_valid_nxt;
  spll_pkg::out_item_t out_data_r, out_data_nxt;

  logic [ID_W-1:0] pmem [CAP];
  logic [ID_W-1:0] nmem [CAP];
  logic [CAP-1:0]  pval_r, nval_r;
  logic [ID_W-1:0] prd_r, nrd_r;
  logic            prdv_r, nrdv_r;
  logic [ID_W-1:0] prv_val, nxt_val;

  logic             pwe, nwe;
  logic [IDX_W-1:0] pwa, nwa;
  logic [ID_W-1:0]  pwd, nwd;

  logic               in_fire, out_fire, out_load;
  logic               id_ok, lf_full, scan_found;
  logic [IDX_W-1:0]   id_idx;
  logic [CAP+SW-1:0]  used_ext, used_sh;
  logic [SW-1:0]      win;
  logic [SK_W-1:0]    scan_k;

  assign in_stall  = (state_r != spll_pkg::S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_load  = (state_r == spll_pkg::S_FIN) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign id_ok   = spll_pkg::id_in_range(id_r);
  assign id_idx  = spll_pkg::idx_of(id_r);
  assign lf_full = !spll_pkg::id_in_range(lf_r);
  assign prv_val = prdv_r ? prd_r : '0;
  assign nxt_val = nrdv_r ? nrd_r : '0;

  assign used_ext = {{SW{1'b0}}, used_r};
  assign used_sh  = used_ext >> (lf_r - ID_W'(1));
  assign win      = used_sh[SW-1:0];

  always_comb begin
    scan_found = 1'b0;
    scan_k     = '0;
    for (int k = SW - 1; k >= 0; k--) begin
      if (!win[k]) begin
        scan_found = 1'b1;
        scan_k     = SK_W'(k);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spll_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_data.func == spll_pkg::FN_ALLOC) begin
            state_nxt = lf_full ? spll_pkg::S_FIN : spll_pkg::S_ALW1;
          end else if ((in_data.func == spll_pkg::FN_FREE ||
                        in_data.func == spll_pkg::FN_QUERY) &&
                       spll_pkg::id_in_range(in_data.slot_id)) begin
            state_nxt = spll_pkg::S_RD;
          end else begin
            state_nxt = spll_pkg::S_FIN;
          end
        end
      end
      spll_pkg::S_ALW1: state_nxt = spll_pkg::S_ALW2;
      spll_pkg::S_ALW2: state_nxt = spll_pkg::S_SCAN;
      spll_pkg::S_SCAN: begin
        if (scan_found) state_nxt = spll_pkg::S_FIN;
      end
      spll_pkg::S_RD:   state_nxt = spll_pkg::S_LNK;
      spll_pkg::S_LNK:  state_nxt = spll_pkg::S_FIN;
      spll_pkg::S_FIN: begin
        if (out_load) state_nxt = spll_pkg::S_IDLE;
      end
      default: state_nxt = spll_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt       = op_r;
    id_nxt       = id_r;
    stat_nxt     = stat_r;
    rid_nxt      = rid_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    lf_nxt       = lf_r;
    used_nxt     = used_r;
    pwe          = 1'b0;
    nwe          = 1'b0;
    pwa          = '0;
    nwa          = '0;
    pwd          = '0;
    nwd          = '0;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r;
    if (out_fire) out_valid_nxt = 1'b0;
    unique case (state_r)
      spll_pkg::S_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_data.func;
          id_nxt   = in_data.slot_id;
          rid_nxt  = '0;
          stat_nxt = spll_pkg::STAT_BAD;
          if (in_data.func == spll_pkg::FN_ALLOC && lf_full) begin
            stat_nxt = spll_pkg::STAT_FULL;
          end
        end
      end
      spll_pkg::S_ALW1: begin
        pwe      = 1'b1;
        pwa      = spll_pkg::idx_of(lf_r);
        pwd      = tail_r;
        nwe      = 1'b1;
        nwa      = spll_pkg::idx_of(lf_r);
        nwd      = head_r;
        used_nxt[spll_pkg::idx_of(lf_r)] = 1'b1;
        rid_nxt  = lf_r;
        stat_nxt = spll_pkg::STAT_OK;
      end
      spll_pkg::S_ALW2: begin
        pwe      = spll_pkg::id_in_range(head_r);
        pwa      = spll_pkg::idx_of(head_r);
        pwd      = rid_r;
        nwe      = spll_pkg::id_in_range(tail_r);
        nwa      = spll_pkg::idx_of(tail_r);
        nwd      = rid_r;
        tail_nxt = rid_r;
        cnt_nxt  = cnt_r + ID_W'(1);
        lf_nxt   = rid_r + ID_W'(1);
      end
      spll_pkg::S_SCAN: begin
        lf_nxt = scan_found ? lf_r + ID_W'(scan_k) : lf_r + ID_W'(SW);
      end
      spll_pkg::S_RD: begin
      end
      spll_pkg::S_LNK: begin
        if (used_r[id_idx]) begin
          stat_nxt = spll_pkg::STAT_OK;
          if (op_r == spll_pkg::FN_FREE) begin
            used_nxt[id_idx] = 1'b0;
            if (head_r == id_r) head_nxt = nxt_val;
            if (tail_r == id_r) tail_nxt = prv_val;
            if (id_r < lf_r) lf_nxt = id_r;
            nwe = spll_pkg::id_in_range(prv_val);
            nwa = spll_pkg::idx_of(prv_val);
            nwd = nxt_val;
            pwe = spll_pkg::id_in_range(nxt_val);
            pwa = spll_pkg::idx_of(nxt_val);
            pwd = prv_val;
            if (cnt_r != '0) cnt_nxt = cnt_r - ID_W'(1);
            if (cnt_r <= ID_W'(1)) begin
              head_nxt = ID_W'(1);
              tail_nxt = ID_W'(1);
            end
          end
        end
      end
      spll_pkg::S_FIN: begin
        if (out_load) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = stat_r;
          out_data_nxt.result_id  = rid_r;
          out_data_nxt.prev_link  = '0;
          out_data_nxt.next_link  = '0;
          out_data_nxt.entry_used = 1'b0;
          if (op_r == spll_pkg::FN_QUERY && id_ok) begin
            out_data_nxt.prev_link  = prv_val;
            out_data_nxt.next_link  = nxt_val;
            out_data_nxt.entry_used = used_r[id_idx];
          end
          out_data_nxt.live_count = cnt_r;
          out_data_nxt.head_slot  = head_r;
          out_data_nxt.tail_slot  = tail_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spll_pkg::S_IDLE;
      head_r      <= ID_W'(1);
      tail_r      <= ID_W'(1);
      cnt_r       <= '0;
      lf_r        <= ID_W'(1);
      used_r      <= '0;
      pval_r      <= '0;
      nval_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      lf_r        <= lf_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (pwe) pval_r[pwa] <= 1'b1;
      if (nwe) nval_r[nwa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    stat_r     <= stat_nxt;
    rid_r      <= rid_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (pwe) pmem[pwa] <= pwd;
    if (nwe) nmem[nwa] <= nwd;
    prd_r  <= pmem[id_idx];
    nrd_r  <= nmem[id_idx];
    prdv_r <= pval_r[id_idx];
    nrdv_r <= nval_r[id_idx];
  end

endmodule
`default_nettype wire

[src/spll_checker.sv]
// Port checker for the slot pool linked list core, bound to the core module.
`default_nettype none
module spll_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire spll_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire spll_pkg::out_item_t out_data
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous item in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == spll_pkg::STAT_FULL |->
      out_data.result_id == '0 &&
      out_data.live_count == spll_pkg::ID_W'(spll_pkg::CAPACITY))
    else $error("pool full reported with free slots");

  a_alloc_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_id != '0 |->
      out_data.status == spll_pkg::STAT_OK && out_data.live_count != '0 &&
      out_data.tail_slot == out_data.result_id)
    else $error("allocated slot not at tail");

endmodule

bind slot_pool_linked_list_core spll_checker u_spll_checker (.*);
`default_nettype wire
